>>> sv/deq_pkg.sv
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [2:0] KIND_POP_BACK   = 3'd2;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [2:0] KIND_CLEAR      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [CNT_W-1:0]   fill_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cmd_t;

endpackage

>>> sv/deq_ctrl.sv
// Sequencer for the double-ended queue: accept, execute, load result.
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output deq_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign cmd.capture = req_valid && (state_reg == S_IDLE);
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.load    = (state_reg == S_LOAD) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // wait until the output register is free or drains this cycle
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_EXEC))
        else $error("accepted transfer did not start execution");

    a_exec_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_LOAD))
        else $error("execution did not move to result load");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> rsp_valid)
        else $error("loaded result not presented");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
        else $error("stalled result dropped");

endmodule

>>> sv/deq_datapath.sv
// Ring storage, head and occupancy registers and result register of the queue.
module deq_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  deq_pkg::cmd_t cmd,
    input  deq_pkg::req_t req,
    output deq_pkg::rsp_t rsp
);

    localparam int PW = deq_pkg::PTR_W;
    localparam int CW = deq_pkg::CNT_W;
    localparam logic [PW:0]   DEPTH_S = (PW + 1)'(deq_pkg::DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(deq_pkg::DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(deq_pkg::DEPTH - 1);

    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[PW-1:0];
    endfunction

    logic signed [31:0] mem [deq_pkg::DEPTH];

    logic [2:0]         kind_reg;
    logic signed [31:0] word_reg;
    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [1:0]         status_reg, status_next;
    logic               pop_ok_reg, pop_ok_next;
    logic signed [31:0] rd_data_reg;
    deq_pkg::rsp_t      rsp_reg;

    logic               full, empty, wr_en;
    logic [PW-1:0]      idx;

    assign full  = (occ_reg == DEPTH_C);
    assign empty = (occ_reg == '0);
    assign rsp   = rsp_reg;

    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        status_next = deq_pkg::ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        idx         = head_reg;
        case (kind_reg)
            deq_pkg::KIND_PUSH_BACK:
            begin
                idx = ring_add(head_reg, occ_reg[PW-1:0]);
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    occ_next = occ_reg + 1'b1;
                end
            end
            deq_pkg::KIND_PUSH_FRONT:
            begin
                idx = (head_reg == '0) ? LAST_P : head_reg - 1'b1;
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    head_next = idx;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            deq_pkg::KIND_POP_BACK:
            begin
                idx = ring_add(head_reg, PW'(occ_reg - 1'b1));
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    occ_next    = occ_reg - 1'b1;
                end
            end
            deq_pkg::KIND_POP_FRONT:
            begin
                idx = head_reg;
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    head_next   = ring_add(head_reg, PW'(1));
                    occ_next    = occ_reg - 1'b1;
                end
            end
            deq_pkg::KIND_CLEAR:
            begin
                head_next = '0;
                occ_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    // ring storage: one registered read per execute cycle, plus a write to the same slot on a successful push
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                mem[idx] <= word_reg;
            end
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req.kind;
            word_reg <= req.data_in;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (cmd.load)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.data_out   <= pop_ok_reg ? rd_data_reg : 32'sd0;
            rsp_reg.fill_count <= occ_reg;
        end
    end

endmodule

>>> sv/double_ended_queue.sv
// Top level of the double-ended queue: controller plus ring datapath.
//
// Request channel (req_valid, req_stall, req): one operation per transfer,
// push back, push front, pop back, pop front or clear, with the word to push.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one result per
// operation, in order: status, popped word (zero unless a pop succeeded)
// and the number of words held afterward.
// Each operation passes through three steps: capture, execute (the ring access and
// the head/occupancy update), then load into the output register. The next
// request is taken only after the previous one has been loaded, so the queue
// does not accept a new operation while one is still in progress.
// The output register holds a result while the receiver stalls; a new
// request is still taken and executed, and its result waits in the load
// step until the output register drains.
// Reset empties the queue (head and occupancy go to zero) and clears any
// pending response; ring contents are not cleared and need no clearing.
module double_ended_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  deq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output deq_pkg::rsp_t rsp
);

    deq_pkg::cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    deq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> tb/sv/double_ended_queue_test.sv
// Self-checking testbench for the double-ended queue: directed and random operations.
module double_ended_queue_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int GAP_MAX = 10;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;
    localparam int TRACK_W = 6;
    localparam int TRACK_DEPTH = 64;
    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST = 3'd7;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    deq_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    deq_pkg::rsp_t rsp;

    // Predictor state: ring contents, front slot and number of words held.
    logic signed [31:0] ring_words [deq_pkg::DEPTH];
    logic [deq_pkg::PTR_W-1:0] front_slot = '0;
    logic [deq_pkg::CNT_W-1:0] words_held = '0;

    // Predicted results waiting for their response transfer, oldest first.
    deq_pkg::rsp_t expected_results [TRACK_DEPTH];
    int expected_written = 0;
    int expected_taken = 0;
    int mismatch_count = 0;
    int sender_gap_max = GAP_MAX;
    int receiver_gap_max = GAP_MAX;
    int stall_hold_cycles = 0;

    double_ended_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic deq_pkg::rsp_t predict_operation(deq_pkg::req_t op);
        deq_pkg::rsp_t r;
        logic [deq_pkg::PTR_W-1:0] slot;
        r = '0;
        r.status = deq_pkg::ST_OK;
        case (op.kind)
            deq_pkg::KIND_PUSH_BACK, deq_pkg::KIND_PUSH_FRONT:
            begin
                if (words_held == deq_pkg::DEPTH)
                begin
                    r.status = deq_pkg::ST_FULL;
                end
                else
                begin
                    if (op.kind == deq_pkg::KIND_PUSH_BACK)
                    begin
                        slot = deq_pkg::PTR_W'((front_slot + words_held) % deq_pkg::DEPTH);
                    end
                    else
                    begin
                        front_slot = deq_pkg::PTR_W'((front_slot + deq_pkg::DEPTH - 1)
                                                     % deq_pkg::DEPTH);
                        slot = front_slot;
                    end
                    ring_words[slot] = op.data_in;
                    words_held = words_held + 1'b1;
                end
            end
            deq_pkg::KIND_POP_BACK, deq_pkg::KIND_POP_FRONT:
            begin
                if (words_held == 0)
                begin
                    r.status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    if (op.kind == deq_pkg::KIND_POP_BACK)
                    begin
                        slot = deq_pkg::PTR_W'((front_slot + words_held - 1)
                                               % deq_pkg::DEPTH);
                    end
                    else
                    begin
                        slot = front_slot;
                        front_slot = deq_pkg::PTR_W'((front_slot + 1) % deq_pkg::DEPTH);
                    end
                    r.data_out = ring_words[slot];
                    words_held = words_held - 1'b1;
                end
            end
            deq_pkg::KIND_CLEAR:
            begin
                words_held = '0;
                front_slot = '0;
            end
            default:
            begin
            end
        endcase
        r.fill_count = words_held;
        return r;
    endfunction

    // Predict on every request transfer, then check every response transfer.
    always @(posedge clk)
    begin : scoreboard
        deq_pkg::rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_results[expected_written[TRACK_W-1:0]] = predict_operation(req);
                expected_written++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_written == expected_taken)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected result: status %0d data_out %0d fill_count %0d",
                                 rsp.status, rsp.data_out, rsp.fill_count);
                    end
                end
                else
                begin
                    want = expected_results[expected_taken[TRACK_W-1:0]];
                    expected_taken++;
                    if (rsp.status !== want.status || rsp.data_out !== want.data_out ||
                        rsp.fill_count !== want.fill_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch at %0t: expected status %0d data_out %0d fill %0d,",
                                     $realtime, want.status, want.data_out, want.fill_count);
                            $display("    got status %0d data_out %0d fill %0d",
                                     rsp.status, rsp.data_out, rsp.fill_count);
                        end
                    end
                end
            end
        end
    end

    // Receiver: stall a random number of cycles before each transfer, or hold
    // off for a long stretch when a test asks for it.
    initial
    begin : receiver
        int pause;
        @(posedge rst_n);
        forever
        begin
            if (stall_hold_cycles > 0)
            begin
                pause = stall_hold_cycles;
                stall_hold_cycles = 0;
            end
            else
            begin
                pause = $urandom_range(0, receiver_gap_max);
            end
            if (pause > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one operation after a random gap and hold it until the transfer.
    task automatic send_operation(input logic [2:0] op, input logic signed [31:0] word);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{kind: op, data_in: word};
        do @(posedge clk); while (req_stall);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT;
    endfunction

    // Mostly pushes and pops at random ends; now and then a clear or an unused kind.
    task automatic send_random_operation(input int push_pct);
        int roll;
        logic [2:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            op = deq_pkg::KIND_CLEAR;
        end
        else if (roll < 4)
        begin
            op = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        end
        else if ($urandom_range(0, 99) < push_pct)
        begin
            op = pick_push();
        end
        else
        begin
            op = pick_pop();
        end
        send_operation(op, pick_word());
    endtask

    task automatic test_empty_queue();
        send_operation(deq_pkg::KIND_POP_BACK, WORD_MAX);
        send_operation(deq_pkg::KIND_POP_FRONT, WORD_MIN);
        send_operation(deq_pkg::KIND_CLEAR, '1);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
        begin
            send_operation(k[2:0], $urandom);
        end
    endtask

    task automatic test_word_extremes();
        send_operation(deq_pkg::KIND_PUSH_BACK, WORD_MAX);
        send_operation(deq_pkg::KIND_PUSH_FRONT, WORD_MIN);
        send_operation(deq_pkg::KIND_PUSH_BACK, '1);
        send_operation(deq_pkg::KIND_PUSH_FRONT, '0);
        send_operation(KIND_UNUSED_LAST, WORD_MAX);
        send_operation(deq_pkg::KIND_POP_BACK, '0);
        send_operation(deq_pkg::KIND_POP_FRONT, '0);
        send_operation(deq_pkg::KIND_POP_BACK, '0);
        // last word leaves through the back end
        send_operation(deq_pkg::KIND_POP_BACK, '0);
        send_operation(deq_pkg::KIND_POP_FRONT, '0);
        send_operation(deq_pkg::KIND_PUSH_FRONT, $urandom);
        send_operation(deq_pkg::KIND_PUSH_BACK, $urandom);
        send_operation(deq_pkg::KIND_CLEAR, '0);
        send_operation(deq_pkg::KIND_POP_FRONT, '0);
        send_operation(deq_pkg::KIND_PUSH_BACK, $urandom);
        send_operation(deq_pkg::KIND_POP_FRONT, '0);
    endtask

    task automatic test_full_queue();
        for (int n = 0; n < deq_pkg::DEPTH; n++)
        begin
            send_operation(pick_push(), pick_word());
        end
        send_operation(deq_pkg::KIND_PUSH_BACK, pick_word());
        send_operation(deq_pkg::KIND_PUSH_FRONT, pick_word());
        for (int n = 0; n < deq_pkg::DEPTH; n++)
        begin
            send_operation(pick_pop(), '0);
        end
        send_operation(deq_pkg::KIND_POP_BACK, '0);
        send_operation(deq_pkg::KIND_POP_FRONT, '0);
    endtask

    // Hold the receiver off while requests keep coming back to back.
    task automatic test_output_hold();
        sender_gap_max = 0;
        stall_hold_cycles = HOLD_OFF_CYCLES;
        repeat (40) send_random_operation(60);
        sender_gap_max = GAP_MAX;
    endtask

    task automatic test_random_mix();
        int push_pct;
        for (int round = 0; round < 26; round++)
        begin
            case (round % 4)
                0:
                begin
                    sender_gap_max = 0;
                    receiver_gap_max = 0;
                end
                1:
                begin
                    sender_gap_max = GAP_MAX;
                    receiver_gap_max = 0;
                end
                2:
                begin
                    sender_gap_max = 0;
                    receiver_gap_max = GAP_MAX;
                end
                default:
                begin
                    sender_gap_max = GAP_MAX;
                    receiver_gap_max = GAP_MAX;
                end
            endcase
            // cycle through filling, draining and mixed rounds so both limits are hit often
            case (round % 3)
                0: push_pct = 85;
                1: push_pct = 20;
                default: push_pct = $urandom_range(35, 65);
            endcase
            repeat (50) send_random_operation(push_pct);
        end
        sender_gap_max = GAP_MAX;
        receiver_gap_max = GAP_MAX;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_word_extremes();
        test_full_queue();
        test_output_hold();
        test_random_mix();
        req_valid <= 1'b0;
        while (expected_written != expected_taken)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> double_ended_queue.f
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_datapath.sv
sv/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
